FILE: hdl/pfx_eval_pkg.sv
// package for the postfix evaluator: types, status codes, character codes
// no dependencies
package pfx_eval_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int WORD_W          = 32;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_POW   = 8'h5E;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_UNDER    = 3'd1,
        ST_OVER     = 3'd2,
        ST_DIVZERO  = 3'd3,
        ST_LEFTOVER = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_OPS,
        S_MUL,
        S_DIV,
        S_POW,
        S_PUSH,
        S_FIN,
        S_OUT
    } t_state;

endpackage

FILE: hdl/postfix_expression_evaluator.sv
// Postfix evaluator: one character per input word. A digit pushes; an operator
// pops two operands, combines them and pushes. A digit passes S_RD1, S_PUSH and
// S_FIN; + - or an unknown operator also passes S_RD2 and S_OPS (two stack reads
// from the RAM, one write). Underflow, a full stack or a sticky error end the
// word in S_RD1, a zero divisor in S_OPS. * adds a shift-add multiply, / adds a
// restoring divider, and ^ runs square-and-multiply on the multiply's shared
// adder, with up to two multiplies per exponent bit. The block is not ready while
// a word is in work. The final word passes through S_OUT to load the output
// register; the result sits there until taken while the block goes on taking
// words, and the next final word waits in S_OUT only while the earlier result is held.
// depends on pfx_eval_pkg and pfx_eval_ram
module postfix_expression_evaluator
    import pfx_eval_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_symbol,
    input  logic               i_last,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_value,
    output logic [2:0]         o_status
);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int PW = $clog2(STACK_DEPTH + 1);

    t_state r_state, n_state;
    logic [PW-1:0] r_sp, n_sp;
    t_status r_err, n_err;
    logic [7:0] r_sym;
    logic r_last;
    logic [31:0] r_l, r_r, r_acc, r_a, r_b, r_ex;
    logic [31:0] n_l, n_r, n_acc, n_a, n_b, n_ex;
    logic [5:0] r_cnt, n_cnt;
    logic r_neg, n_neg, r_psq, n_psq;
    logic r_val, n_val;
    logic [31:0] r_value, n_value;
    logic [2:0] r_status, n_status;

    logic ram_we;
    logic [AW-1:0] ram_wa, ram_ra;
    logic [31:0] ram_wd, ram_rd;

    pfx_eval_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_wa), .i_wdata(ram_wd),
        .i_raddr(ram_ra), .o_rdata(ram_rd)
    );

    logic is_digit;
    assign is_digit = (r_sym >= CH_ZERO) && (r_sym <= CH_NINE);

    // earlier result still waiting at the output
    logic out_hold;
    assign out_hold = r_val && i_stall;

    t_status fin_status;
    always_comb begin
        fin_status = r_err;
        if (r_err == ST_OK) begin
            if (r_sp == PW'(0)) fin_status = ST_UNDER;
            else if (r_sp > PW'(1)) fin_status = ST_LEFTOVER;
        end
    end

    // multiply adder (shared by * and ^) and divide trial subtractor
    logic [31:0] sum;
    logic [32:0] dtrial;
    assign sum    = r_acc + r_a;
    assign dtrial = {r_acc, r_a[31]} - {1'b0, r_b};

    logic [31:0] lmag, rmag;
    assign lmag = r_l[31] ? 32'(0 - r_l) : r_l;
    assign rmag = r_r[31] ? 32'(0 - r_r) : r_r;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_val;
    assign o_value = r_value;
    assign o_status = r_status;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid && !o_stall) n_state = S_RD1;
            S_RD1: begin
                if (r_err != ST_OK) n_state = S_FIN;
                else if (is_digit) n_state = (r_sp >= PW'(STACK_DEPTH)) ? S_FIN : S_PUSH;
                else n_state = (r_sp < PW'(2)) ? S_FIN : S_RD2;
            end
            S_RD2: n_state = S_OPS;
            S_OPS: begin
                case (r_sym)
                    CH_MUL: n_state = S_MUL;
                    CH_DIV: n_state = (r_r == 32'd0) ? S_FIN : S_DIV;
                    CH_POW: n_state = r_r[31] ? S_PUSH : S_POW;
                    default: n_state = S_PUSH;
                endcase
            end
            S_MUL: if (r_cnt == 6'd31) n_state = S_PUSH;
            S_DIV: if (r_cnt == 6'd31) n_state = S_PUSH;
            S_POW: if (r_ex == 32'd0 && r_cnt == 6'd0 && !r_psq) n_state = S_PUSH;
            S_PUSH: n_state = S_FIN;
            S_FIN: n_state = r_last ? S_OUT : S_IDLE;
            S_OUT: n_state = out_hold ? S_OUT : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_sp = r_sp; n_err = r_err;
        n_l = r_l; n_r = r_r; n_acc = r_acc; n_a = r_a; n_b = r_b; n_ex = r_ex;
        n_cnt = r_cnt; n_neg = r_neg; n_psq = r_psq;
        n_val = r_val; n_value = r_value; n_status = r_status;
        ram_we = 1'b0; ram_wa = AW'(r_sp); ram_wd = r_acc;
        ram_ra = AW'(r_sp - PW'(1));
        if (r_val && !i_stall) n_val = 1'b0;
        case (r_state)
            S_IDLE: ram_ra = AW'(r_sp - PW'(1));
            S_RD1: begin
                ram_ra = AW'(r_sp - PW'(2));
                if (r_err == ST_OK) begin
                    if (is_digit) begin
                        if (r_sp >= PW'(STACK_DEPTH)) n_err = ST_OVER;
                        else n_acc = {28'd0, 4'(r_sym - CH_ZERO)};
                    end else if (r_sp < PW'(2)) begin
                        n_err = ST_UNDER;
                    end else begin
                        n_r = ram_rd;
                    end
                end
            end
            S_RD2: begin
                // left operand sits one below the top
                n_l = ram_rd;
                n_sp = r_sp - PW'(2);
            end
            S_OPS: begin
                // note: here r_r = right operand, r_l = left operand
                n_cnt = 6'd0;
                case (r_sym)
                    CH_PLUS:  n_acc = r_l + r_r;
                    CH_MINUS: n_acc = r_l - r_r;
                    CH_MUL: begin
                        n_acc = 32'd0; n_a = r_l; n_b = r_r;
                    end
                    CH_DIV: begin
                        if (r_r == 32'd0) n_err = ST_DIVZERO;
                        n_acc = 32'd0; n_a = lmag; n_b = rmag;
                        n_neg = r_l[31] ^ r_r[31];
                    end
                    CH_POW: begin
                        if (r_r[31]) begin
                            if (r_l == 32'd1) n_acc = 32'd1;
                            else if (r_l == 32'hFFFF_FFFF)
                                n_acc = r_r[0] ? 32'hFFFF_FFFF : 32'd1;
                            else n_acc = 32'd0;
                        end else begin
                            // r_l = result, r_r = base, n_ex = exponent
                            n_ex = r_r; n_r = r_l; n_l = 32'd1; n_psq = 1'b0;
                        end
                    end
                    default: n_acc = 32'd0;
                endcase
            end
            S_MUL, S_POW: begin
                if (r_cnt == 6'd0 && r_state == S_POW) begin
                    // start next multiply: result*base if bit set, else square
                    if (!r_psq && r_ex != 32'd0) begin
                        n_acc = 32'd0;
                        if (r_ex[0]) begin
                            n_a = r_l; n_b = r_r; n_psq = 1'b1;
                        end else begin
                            n_a = r_r; n_b = r_r; n_psq = 1'b1;
                        end
                        n_cnt = 6'd1;
                    end else if (r_ex == 32'd0) begin
                        n_acc = r_l;
                        n_psq = 1'b0;
                    end
                end else begin
                    // shift-add step: acc += a if b lsb, a <<= 1, b >>= 1
                    if (r_b[0]) n_acc = sum;
                    n_a = {r_a[30:0], 1'b0};
                    n_b = {1'b0, r_b[31:1]};
                    n_cnt = r_cnt + 6'd1;
                    if (r_state == S_MUL) begin
                        if (r_cnt == 6'd31) n_cnt = 6'd0;
                    end else if (r_cnt == 6'd32) begin
                        // multiply done: the final step's sum goes into the result or the base
                        n_cnt = 6'd0; n_psq = 1'b0;
                        if (r_ex[0]) begin
                            n_l = r_b[0] ? sum : r_acc;
                            n_ex = {r_ex[31:1], 1'b0};
                        end else begin
                            n_r = r_b[0] ? sum : r_acc;
                            n_ex = {1'b0, r_ex[31:1]};
                        end
                    end
                end
            end
            S_DIV: begin
                // restoring division: acc remainder, a shifts dividend out, quotient in, b divisor
                n_a = {r_a[30:0], ~dtrial[32]};
                n_acc = dtrial[32] ? {r_acc[30:0], r_a[31]} : dtrial[31:0];
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    n_acc = r_neg ? 32'(0 - {r_a[30:0], ~dtrial[32]})
                                  : {r_a[30:0], ~dtrial[32]};
                    n_cnt = 6'd0;
                end
            end
            S_PUSH: begin
                ram_we = 1'b1; ram_wa = AW'(r_sp); ram_wd = r_acc;
                n_sp = r_sp + PW'(1);
            end
            S_FIN: ram_ra = AW'(0);
            S_OUT: begin
                ram_ra = AW'(0);
                if (!out_hold) begin
                    n_status = fin_status;
                    n_value = (fin_status == ST_OK) ? ram_rd : 32'd0;
                    n_val = 1'b1;
                    n_sp = '0; n_err = ST_OK;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_sp <= '0; r_err <= ST_OK;
            r_val <= 1'b0; r_cnt <= '0; r_psq <= 1'b0;
        end else begin
            r_state <= n_state; r_sp <= n_sp; r_err <= n_err;
            r_val <= n_val; r_cnt <= n_cnt; r_psq <= n_psq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid && !o_stall) begin
            r_sym <= i_symbol; r_last <= i_last;
        end
        r_l <= n_l; r_r <= n_r; r_acc <= n_acc; r_a <= n_a; r_b <= n_b;
        r_ex <= n_ex; r_neg <= n_neg;
        r_value <= n_value; r_status <= n_status;
    end

`ifndef SYNTHESIS
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= PW'(STACK_DEPTH)) else $error("stack pointer out of range");
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall) else $error("ready while busy");
    a_out_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !out_hold) |=> (r_sp == '0 && r_err == ST_OK && r_val))
        else $error("end of expression not cleared");
    a_err_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_val && r_status != ST_OK) |-> (r_value == 32'd0))
        else $error("nonzero value with error");
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_value) && $stable(o_status)))
        else $error("held result changed");
`endif
endmodule

FILE: hdl/pfx_eval_ram.sv
// generic single-port-write, one-read RAM with registered read
// no dependencies
module pfx_eval_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: tb/sv/testbench.sv
// testbench for postfix_expression_evaluator: directed table and cases, a held receiver, then random expressions
// checks each result against an in-bench stack evaluator; depends on pfx_eval_pkg and postfix_expression_evaluator
module testbench;
    import pfx_eval_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = STACK_DEPTH_DEF;
    localparam int WATCHDOG = 200000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [7:0]        i_symbol;
    logic              i_last;
    logic              o_valid;
    logic              i_stall;
    logic signed [31:0] o_value;
    logic [2:0]        o_status;

    postfix_expression_evaluator DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_symbol(i_symbol), .i_last(i_last), .o_valid(o_valid), .i_stall(i_stall),
        .o_value(o_value), .o_status(o_status)
    );

    typedef struct {
        logic [31:0] value;
        t_status     status;
    } t_result;

    // predictor state
    logic [31:0] eval_stack [DEPTH];
    int          eval_sp;
    t_status     eval_err;
    t_result     pending_results [$];

    int  fail_count;
    int  idle_cycles;
    bit  quiet_mode;     // no idling on either side
    bit  hold_rx;        // receiver held off for a long stretch
    int  hold_cnt;

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    function automatic logic [31:0] mul_wrap(logic [31:0] a, logic [31:0] b);
        logic [63:0] p;
        p = a * b;
        return p[31:0];
    endfunction

    function automatic logic [31:0] div_trunc(logic [31:0] a, logic [31:0] b);
        logic [31:0] ma, mb, q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q = ma / mb;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic logic [31:0] int_power(logic [31:0] base, logic [31:0] ex);
        logic [31:0] acc;
        acc = 32'd1;
        if (ex[31]) begin
            if (base == 32'd1) return 32'd1;
            if (base == 32'hFFFF_FFFF) return ex[0] ? 32'hFFFF_FFFF : 32'd1;
            return 32'd0;
        end
        while (ex != 0) begin
            if (ex[0]) acc = mul_wrap(acc, base);
            base = mul_wrap(base, base);
            ex = ex >> 1;
        end
        return acc;
    endfunction

    // one character into the predictor; queues a result on the final word
    task automatic eval_symbol(input logic [7:0] sym, input logic lst);
        logic [31:0] l, r, v;
        t_result res;
        if (eval_err == ST_OK) begin
            if (sym >= CH_ZERO && sym <= CH_NINE) begin
                if (eval_sp >= DEPTH) eval_err = ST_OVER;
                else begin
                    eval_stack[eval_sp] = {24'd0, sym - CH_ZERO};
                    eval_sp++;
                end
            end else if (eval_sp < 2) begin
                eval_err = ST_UNDER;
            end else begin
                r = eval_stack[eval_sp-1];
                l = eval_stack[eval_sp-2];
                eval_sp -= 2;
                v = 32'd0;
                case (sym)
                    CH_PLUS:  v = l + r;
                    CH_MINUS: v = l - r;
                    CH_MUL:   v = mul_wrap(l, r);
                    CH_DIV: begin
                        if (r == 0) eval_err = ST_DIVZERO;
                        else v = div_trunc(l, r);
                    end
                    CH_POW:   v = int_power(l, r);
                    default:  v = 32'd0;
                endcase
                if (eval_err == ST_OK) begin
                    eval_stack[eval_sp] = v;
                    eval_sp++;
                end
            end
        end
        if (lst) begin
            res.value = 32'd0;
            res.status = eval_err;
            if (eval_err == ST_OK) begin
                if (eval_sp == 0) res.status = ST_UNDER;
                else if (eval_sp > 1) res.status = ST_LEFTOVER;
                else res.value = eval_stack[0];
            end
            pending_results.push_back(res);
            eval_sp = 0;
            eval_err = ST_OK;
        end
    endtask

    // directed table; exp_status is ST_OK with chk 0 where only the predictor is used
    typedef struct {
        logic [7:0]  sym;
        logic        lst;
        bit          chk;
        logic [31:0] exp_value;
        t_status     exp_status;
    } t_row;

    t_row dir_table [$];
    t_result typed_results [$];  // typed-in expectations, parallel to pending_results
    bit      typed_valid [$];

    task automatic add_row(input logic [7:0] s, input logic l, input bit c,
                           input logic [31:0] v, input t_status st);
        t_row r;
        r.sym = s; r.lst = l; r.chk = c; r.exp_value = v; r.exp_status = st;
        dir_table.push_back(r);
    endtask

    // valid stays high from word to word; it drops only while idling
    task automatic send_word(input logic [7:0] s, input logic l, input bit c,
                             input logic [31:0] v, input t_status st);
        t_result tr;
        if (!quiet_mode && $urandom_range(99) < 24) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < 24) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_symbol <= s;
        i_last   <= l;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        eval_symbol(s, l);
        if (l) begin
            tr.value = v; tr.status = st;
            typed_results.push_back(tr);
            typed_valid.push_back(c);
        end
    endtask

    task automatic send_plain(input logic [7:0] s, input logic l);
        send_word(s, l, 1'b0, 32'd0, ST_OK);
    endtask

    task automatic idle_input();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_random_expr();
        int n, depth_now, k;
        logic [7:0] ops [5];
        logic [7:0] s;
        ops = '{CH_PLUS, CH_MINUS, CH_MUL, CH_DIV, CH_POW};
        n = $urandom_range(1, 12);
        depth_now = 0;
        k = $urandom_range(99);
        if (k < 75) begin
            // well-formed: push digits, apply ops while depth allows
            for (int i = 0; i < n || depth_now != 1; i++) begin
                if (depth_now >= 2 && ($urandom_range(1) == 1 || i >= n)) begin
                    s = ops[$urandom_range(4)];
                    if (s == CH_POW && $urandom_range(3) != 0) s = CH_MUL;
                    if ($urandom_range(30) == 0) s = 8'($urandom_range(255));
                    depth_now--;
                end else begin
                    s = CH_ZERO + 8'($urandom_range(9));
                    depth_now++;
                end
                if (i > 40) break;
                send_plain(s, 1'b0);
            end
            send_plain(CH_ZERO + 8'($urandom_range(9)), 1'b0);
            send_plain(CH_PLUS, 1'b1);
        end else if (k < 80) begin
            // fill the stack past its depth
            for (int i = 0; i < DEPTH + 1; i++)
                send_plain(CH_ZERO + 8'($urandom_range(9)), 1'b0);
            send_plain(CH_PLUS, 1'b1);
        end else begin
            // noise: any characters
            for (int i = 0; i < n; i++) begin
                s = ($urandom_range(1) == 1) ? CH_ZERO + 8'($urandom_range(9))
                                             : 8'($urandom_range(255));
                send_plain(s, (i == n - 1));
            end
        end
    endtask

    // receiver stall and checking
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            hold_cnt <= 0;
        end else begin
            if (hold_rx) begin
                i_stall <= 1'b1;
                hold_cnt <= hold_cnt + 1;
            end else begin
                i_stall <= quiet_mode ? 1'b0 : ($urandom_range(99) < 24);
            end
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result value %0d status %0d",
                             $time, o_value, o_status);
                    fail_count++;
                end else begin
                    t_result e;
                    bit tv;
                    t_result t;
                    e = pending_results.pop_front();
                    t = typed_results.pop_front();
                    tv = typed_valid.pop_front();
                    if (tv && (t.value !== e.value || t.status !== e.status)) begin
                        $display("%0t: table entry disagrees: expected %0d/%0d %s %0d/%0d",
                                 $time, $signed(t.value), t.status, "predicted",
                                 $signed(e.value), e.status);
                        fail_count++;
                    end
                    if (o_value !== e.value) begin
                        $display("%0t: value mismatch expected %0d actual %0d",
                                 $time, $signed(e.value), o_value);
                        fail_count++;
                    end
                    if (o_status !== e.status) begin
                        $display("%0t: status mismatch expected %0d actual %0d",
                                 $time, e.status, o_status);
                        fail_count++;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no accepted word and no taken result
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0; i_valid = 1'b0; i_symbol = 8'd0; i_last = 1'b0;
        eval_sp = 0; eval_err = ST_OK;
        quiet_mode = 0; hold_rx = 0;

        // "1" -> 1; "9" -> 9; "0" -> 0
        add_row(CH_ZERO + 8'd1, 1'b1, 1'b1, 32'd1, ST_OK);
        add_row(CH_NINE, 1'b1, 1'b1, 32'd9, ST_OK);
        add_row(CH_ZERO, 1'b1, 1'b1, 32'd0, ST_OK);
        // lone operator: underflow
        add_row(CH_PLUS, 1'b1, 1'b1, 32'd0, ST_UNDER);
        // "23" leftover
        add_row(CH_ZERO + 8'd2, 1'b0, 1'b0, 32'd0, ST_OK);
        add_row(CH_ZERO + 8'd3, 1'b1, 1'b1, 32'd0, ST_LEFTOVER);
        // "50/" divide by zero, then sticky ignores the digit
        add_row(CH_ZERO + 8'd5, 1'b0, 1'b0, 32'd0, ST_OK);
        add_row(CH_ZERO, 1'b0, 1'b0, 32'd0, ST_OK);
        add_row(CH_DIV, 1'b0, 1'b0, 32'd0, ST_OK);
        add_row(CH_ZERO + 8'd7, 1'b1, 1'b1, 32'd0, ST_DIVZERO);
        // "00^" -> 1
        add_row(CH_ZERO, 1'b0, 1'b0, 32'd0, ST_OK);
        add_row(CH_ZERO, 1'b0, 1'b0, 32'd0, ST_OK);
        add_row(CH_POW, 1'b1, 1'b1, 32'd1, ST_OK);
        // "34-" -> -1 ; unknown op 8'hFF after "12" -> 0
        add_row(CH_ZERO + 8'd3, 1'b0, 1'b0, 32'd0, ST_OK);
        add_row(CH_ZERO + 8'd4, 1'b0, 1'b0, 32'd0, ST_OK);
        add_row(CH_MINUS, 1'b1, 1'b1, 32'hFFFF_FFFF, ST_OK);
        add_row(CH_ZERO + 8'd1, 1'b0, 1'b0, 32'd0, ST_OK);
        add_row(CH_ZERO + 8'd2, 1'b0, 1'b0, 32'd0, ST_OK);
        add_row(8'hFF, 1'b1, 1'b1, 32'd0, ST_OK);
        // "97*8/" -> 7
        add_row(CH_ZERO + 8'd9, 1'b0, 1'b0, 32'd0, ST_OK);
        add_row(CH_ZERO + 8'd7, 1'b0, 1'b0, 32'd0, ST_OK);
        add_row(CH_MUL, 1'b0, 1'b0, 32'd0, ST_OK);
        add_row(CH_ZERO + 8'd8, 1'b0, 1'b0, 32'd0, ST_OK);
        add_row(CH_DIV, 1'b1, 1'b1, 32'd7, ST_OK);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_table[i])
            send_word(dir_table[i].sym, dir_table[i].lst, dir_table[i].chk,
                      dir_table[i].exp_value, dir_table[i].exp_status);

        // negative exponents: -1 ^ -1 -> -1 ; 2 ^ -1 -> 0 ; 1 ^ -2 -> 1
        send_plain(CH_ZERO, 1'b0);          send_plain(CH_ZERO + 8'd1, 1'b0);
        send_plain(CH_MINUS, 1'b0);         send_plain(CH_ZERO, 1'b0);
        send_plain(CH_ZERO + 8'd1, 1'b0);   send_plain(CH_MINUS, 1'b0);
        send_plain(CH_POW, 1'b1);
        send_plain(CH_ZERO + 8'd2, 1'b0);   send_plain(CH_ZERO, 1'b0);
        send_plain(CH_ZERO + 8'd1, 1'b0);   send_plain(CH_MINUS, 1'b0);
        send_plain(CH_POW, 1'b1);
        send_plain(CH_ZERO + 8'd1, 1'b0);   send_plain(CH_ZERO, 1'b0);
        send_plain(CH_ZERO + 8'd2, 1'b0);   send_plain(CH_MINUS, 1'b0);
        send_plain(CH_POW, 1'b1);
        // most negative / -1: 2 ^ (9*3+4) = 2^31, then divided by 0-1
        send_plain(CH_ZERO + 8'd2, 1'b0);   send_plain(CH_ZERO + 8'd9, 1'b0);
        send_plain(CH_ZERO + 8'd3, 1'b0);   send_plain(CH_MUL, 1'b0);
        send_plain(CH_ZERO + 8'd4, 1'b0);   send_plain(CH_PLUS, 1'b0);
        send_plain(CH_POW, 1'b0);           send_plain(CH_ZERO, 1'b0);
        send_plain(CH_ZERO + 8'd1, 1'b0);   send_plain(CH_MINUS, 1'b0);
        send_word(CH_DIV, 1'b1, 1'b1, 32'h8000_0000, ST_OK);

        // sender pauses until everything has come back
        idle_input();
        wait (pending_results.size() == 0);

        // receiver held off while the sender keeps offering
        hold_rx = 1;
        fork
            begin
                for (int i = 0; i < 6; i++) begin
                    send_plain(CH_ZERO + 8'(i), 1'b0);
                    send_plain(CH_ZERO + 8'd1, 1'b1);
                end
            end
            begin
                wait (hold_cnt >= 400);
                hold_rx = 0;
            end
        join

        for (int i = 0; i < 60; i++) begin
            quiet_mode = (i >= 20 && i < 35);
            send_random_expr();
        end
        quiet_mode = 0;

        idle_input();
        wait (pending_results.size() == 0);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule
